/* src/hsfc_pkg.sv */
// Shared types, constants and the CRC-8 step for the humidity sensor frame checker.
package hsfc_pkg;

	localparam logic [7:0]  CRC_POLY    = 8'h31;
	localparam logic [7:0]  CRC_INIT    = 8'hFF;
	localparam logic [10:0] TEMP_SPAN   = 11'd1750;
	localparam logic [10:0] TEMP_OFFSET = 11'd450;
	localparam logic [9:0]  HUM_SPAN    = 10'd1000;
	localparam logic [16:0] FULL_SCALE  = 17'd65535;
	localparam logic [7:0]  LIMIT_RESET = 8'd10;

	typedef logic [1:0] status_t;
	localparam status_t STAT_OK       = 2'd0;
	localparam status_t STAT_BUS_FAIL = 2'd1;
	localparam status_t STAT_TEMP_CRC = 2'd2;
	localparam status_t STAT_HUM_CRC  = 2'd3;

	// finished frame handed from the front to the back
	typedef struct packed {
		status_t     status;
		logic [15:0] raw_temp;
		logic [15:0] raw_hum;
	} frame_ev_t;

	function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] b);
		logic [7:0] c;
		c = crc_in ^ b;
		for (int i = 0; i < 8; i++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

/* src/hsfc_if.sv */
// Valid/ready stream interfaces for received bytes and frame results.
interface hsfc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       bus_fail;

	modport source(output valid, output rx_byte, output bus_fail, input ready);
	modport sink(input valid, input rx_byte, input bus_fail, output ready);
endinterface

interface hsfc_out_if;
	logic              valid;
	logic              ready;
	logic [1:0]        status;
	logic signed [11:0] temperature_tenths;
	logic [9:0]        humidity_tenths;
	logic              error_flag;
	logic              reset_request;
	logic [7:0]        fail_count;

	modport source(
		output valid, output status, output temperature_tenths, output humidity_tenths,
		output error_flag, output reset_request, output fail_count, input ready
	);
	modport sink(
		input valid, input status, input temperature_tenths, input humidity_tenths,
		input error_flag, input reset_request, input fail_count, output ready
	);
endinterface

/* src/humidity_sensor_frame_checker_top.sv */
// Top level of the humidity sensor frame checker.
//
// rx carries one received byte per beat (rx_byte, bus_fail); result carries
// one beat per finished frame: after the sixth byte, or at once on a beat
// with bus_fail set, which aborts the frame and ignores its byte.
// Status 0 is a good frame, 1 a bus failure, 2 a bad temperature CRC
// (checked first), 3 a bad humidity CRC. Failed frames repeat the last good
// temperature and humidity and bump the consecutive-failure count; when it
// reaches error_limit (cfg_we/cfg_wdata, 10 after reset) reset_request is
// set and the count is cleared.
// One byte is taken per cycle while rx.ready is high. A frame result passes
// through the queue and then a multiply stage, a quotient-estimate stage and
// the correction stage that loads the result register.
// Finished frames wait in a FIFO_DEPTH-entry queue; rx.ready drops only when
// that queue is full, so a stalled receiver blocks rx only after the queue
// and the three back stages have filled.
// Reset clears the frame position, CRC, failure count, last good values and
// all valid flags; no item is lost or repeated around a stall.
module humidity_sensor_frame_checker_top
	import hsfc_pkg::*;
#(
	parameter int FIFO_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata,
	hsfc_in_if.sink    rx,
	hsfc_out_if.source result
);

	logic      push, full, pop, ev_valid;
	frame_ev_t push_ev, ev;

	hsfc_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.rx      (rx),
		.push    (push),
		.push_ev (push_ev),
		.full    (full)
	);

	hsfc_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_ev   (push_ev),
		.full      (full),
		.pop       (pop),
		.pop_valid (ev_valid),
		.pop_ev    (ev)
	);

	hsfc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.ev_valid  (ev_valid),
		.ev        (ev),
		.pop       (pop),
		.result    (result)
	);

endmodule

/* src/hsfc_front.sv */
// Front end: byte framing, CRC-8 checks and frame classification.
module hsfc_front
	import hsfc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	hsfc_in_if.sink   rx,
	output logic      push,
	output frame_ev_t push_ev,
	input  logic      full
);

	logic [2:0]  pos_q;
	logic [7:0]  crc_q;
	logic [15:0] raw_temp_q;
	logic [15:0] raw_hum_q;
	logic        temp_good_q;
	logic        accept;
	logic        frame_end;
	status_t     ev_status;

	assign rx.ready = !full;
	assign accept   = rx.valid && rx.ready;

	always_comb begin
		frame_end = 1'b0;
		ev_status = STAT_OK;
		if (rx.bus_fail) begin
			frame_end = 1'b1;
			ev_status = STAT_BUS_FAIL;
		end else if (pos_q == 3'd5) begin
			frame_end = 1'b1;
			if (!temp_good_q) begin
				ev_status = STAT_TEMP_CRC;
			end else if (rx.rx_byte != crc_q) begin
				ev_status = STAT_HUM_CRC;
			end
		end
	end

	assign push             = accept && frame_end;
	assign push_ev.status   = ev_status;
	assign push_ev.raw_temp = raw_temp_q;
	assign push_ev.raw_hum  = raw_hum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= 3'd0;
			crc_q       <= CRC_INIT;
			raw_temp_q  <= 16'd0;
			raw_hum_q   <= 16'd0;
			temp_good_q <= 1'b0;
		end else if (accept) begin
			if (frame_end) begin
				pos_q <= 3'd0;
				crc_q <= CRC_INIT;
			end else begin
				case (pos_q)
					3'd1: begin
						raw_temp_q <= {raw_temp_q[7:0], rx.rx_byte};
						crc_q      <= crc8_byte(crc_q, rx.rx_byte);
						pos_q      <= 3'd2;
					end
					3'd2: begin
						temp_good_q <= (rx.rx_byte == crc_q);
						crc_q       <= CRC_INIT;
						pos_q       <= 3'd3;
					end
					3'd3: begin
						raw_hum_q <= {8'd0, rx.rx_byte};
						crc_q     <= crc8_byte(CRC_INIT, rx.rx_byte);
						pos_q     <= 3'd4;
					end
					3'd4: begin
						raw_hum_q <= {raw_hum_q[7:0], rx.rx_byte};
						crc_q     <= crc8_byte(crc_q, rx.rx_byte);
						pos_q     <= 3'd5;
					end
					default: begin
						// first byte of a frame
						raw_temp_q <= {8'd0, rx.rx_byte};
						crc_q      <= crc8_byte(CRC_INIT, rx.rx_byte);
						pos_q      <= 3'd1;
					end
				endcase
			end
		end
	end

endmodule

/* src/hsfc_fifo.sv */
// Short register queue of finished frames between front and back.
module hsfc_fifo
	import hsfc_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  frame_ev_t push_ev,
	output logic      full,
	input  logic      pop,
	output logic      pop_valid,
	output frame_ev_t pop_ev
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	frame_ev_t       mem_q [DEPTH];
	logic [PW-1:0]   wr_q;
	logic [PW-1:0]   rd_q;
	logic [CW-1:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign full      = (count_q == CW'(DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_ev    = mem_q[rd_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_ev;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* src/hsfc_back.sv */
// Back end: raw-to-tenths conversion, failure counting and the result register.
module hsfc_back
	import hsfc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata,
	input  logic       ev_valid,
	input  frame_ev_t  ev,
	output logic       pop,
	hsfc_out_if.source result
);

	logic        adv;
	logic        v_s1, v_s2, v_s3;
	status_t     st_s1, st_s2;
	logic [26:0] tp_s1, tp_s2;
	logic [25:0] hp_s1, hp_s2;
	logic [10:0] tq_s2;
	logic [9:0]  hq_s2;
	logic [27:0] tsum;
	logic [26:0] hsum;

	logic [26:0] tmul, tdiff;
	logic [25:0] hmul, hdiff;
	logic [16:0] trem, hrem;
	logic        tfix, hfix, trem_nz, tadj;
	logic [10:0] tq;
	logic [9:0]  hq;
	logic [11:0] temp_new;
	logic [8:0]  cnt_inc;

	logic [7:0]  limit_q;
	logic [7:0]  fail_q;
	logic [11:0] last_temp_q;
	logic [9:0]  last_hum_q;

	status_t     status_s3;
	logic [11:0] temp_s3;
	logic [9:0]  hum_s3;
	logic        err_s3, req_s3;
	logic [7:0]  cnt_s3;

	assign adv = !v_s3 || result.ready;
	assign pop = adv && ev_valid;

	// x / 65535: estimate (x + x>>16) >> 16 is q or q-1
	assign tsum = {1'b0, tp_s1} + {17'd0, tp_s1[26:16]};
	assign hsum = {1'b0, hp_s1} + {17'd0, hp_s1[25:16]};

	always_ff @(posedge clk) begin
		if (adv) begin
			st_s1 <= ev.status;
			tp_s1 <= 27'(TEMP_SPAN) * 27'(ev.raw_temp);
			hp_s1 <= 26'(HUM_SPAN) * 26'(ev.raw_hum);
			st_s2 <= st_s1;
			tp_s2 <= tp_s1;
			hp_s2 <= hp_s1;
			tq_s2 <= tsum[26:16];
			hq_s2 <= hsum[25:16];
		end
	end

	// remainder and one-step correction
	assign tmul    = {tq_s2, 16'd0} - {16'd0, tq_s2};
	assign tdiff   = tp_s2 - tmul;
	assign trem    = tdiff[16:0];
	assign tfix    = (trem >= FULL_SCALE);
	assign tq      = tq_s2 + {10'd0, tfix};
	assign trem_nz = tfix ? (trem != FULL_SCALE) : (trem != 17'd0);
	// truncation toward zero for negative temperatures
	assign tadj     = (tq < TEMP_OFFSET) && trem_nz;
	assign temp_new = {1'b0, tq} - {1'b0, TEMP_OFFSET} + {11'd0, tadj};

	assign hmul = {hq_s2, 16'd0} - {16'd0, hq_s2};
	assign hdiff = hp_s2 - hmul;
	assign hrem  = hdiff[16:0];
	assign hfix  = (hrem >= FULL_SCALE);
	assign hq    = hq_s2 + {9'd0, hfix};

	assign cnt_inc = {1'b0, fail_q} + 9'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			limit_q     <= LIMIT_RESET;
			fail_q      <= 8'd0;
			last_temp_q <= 12'd0;
			last_hum_q  <= 10'd0;
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			if (adv) begin
				v_s1 <= ev_valid;
				v_s2 <= v_s1;
				v_s3 <= v_s2;
				if (v_s2) begin
					if (st_s2 == STAT_OK) begin
						last_temp_q <= temp_new;
						last_hum_q  <= hq;
						fail_q      <= 8'd0;
					end else if (cnt_inc[7:0] >= limit_q) begin
						fail_q <= 8'd0;
					end else begin
						fail_q <= cnt_inc[7:0];
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s2) begin
			status_s3 <= st_s2;
			if (st_s2 == STAT_OK) begin
				temp_s3 <= temp_new;
				hum_s3  <= hq;
				err_s3  <= 1'b0;
				req_s3  <= 1'b0;
				cnt_s3  <= 8'd0;
			end else begin
				temp_s3 <= last_temp_q;
				hum_s3  <= last_hum_q;
				err_s3  <= 1'b1;
				if (cnt_inc[7:0] >= limit_q) begin
					req_s3 <= 1'b1;
					cnt_s3 <= 8'd0;
				end else begin
					req_s3 <= 1'b0;
					cnt_s3 <= cnt_inc[7:0];
				end
			end
		end
	end

	assign result.valid              = v_s3;
	assign result.status             = status_s3;
	assign result.temperature_tenths = $signed(temp_s3);
	assign result.humidity_tenths    = hum_s3;
	assign result.error_flag         = err_s3;
	assign result.reset_request      = req_s3;
	assign result.fail_count         = cnt_s3;

	a_err_matches_status: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> (err_s3 == (status_s3 != STAT_OK)))
		else $error("error flag disagrees with status");

	a_req_clears_count: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && req_s3) |-> (err_s3 && cnt_s3 == 8'd0))
		else $error("reset request without failure or with nonzero count");

	a_good_frame_range: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && status_s3 == STAT_OK) |->
			(hum_s3 <= 10'd1000 && $signed(temp_s3) >= -12'sd450 &&
			 $signed(temp_s3) <= 12'sd1300))
		else $error("converted value out of range");

endmodule
